// ----- src/saag_pkg.sv -----
// Shared constants, types and sine table for the SAME alert generator.
`timescale 1ns / 1ps
package saag_pkg;

	localparam int MSG_DEPTH      = 128;
	localparam int MSG_AW         = $clog2(MSG_DEPTH);
	localparam int PREAMBLE_BYTES = 16;
	localparam int EOM_BYTES      = 16;
	localparam int MAX_MSG_LEN    = 100;
	localparam logic [1:0] REPEATS = 2'd3;
	localparam logic [7:0] PRE_CHAR = 8'hAB;
	localparam logic [7:0] EOM_CHAR = 8'h4E;

	localparam int SINE_BITS = 10;
	localparam int QTR_BITS  = SINE_BITS - 2;
	localparam int QTR_SIZE  = 1 << QTR_BITS;

	// input kinds
	localparam logic [1:0] MODE_PRODUCE = 2'd0;
	localparam logic [1:0] MODE_LOAD    = 2'd1;
	localparam logic [1:0] MODE_RESTART = 2'd2;

	// stage codes as reported on the result
	localparam logic [1:0] STAGE_CODE_HEADER = 2'd0;
	localparam logic [1:0] STAGE_CODE_ATTN   = 2'd1;
	localparam logic [1:0] STAGE_CODE_EOM    = 2'd2;

	// register indexes
	localparam logic [2:0] CFG_MSG_LEN    = 3'd0;
	localparam logic [2:0] CFG_BIT_SAMP   = 3'd1;
	localparam logic [2:0] CFG_GAP_SAMP   = 3'd2;
	localparam logic [2:0] CFG_ATTN_SAMP  = 3'd3;
	localparam logic [2:0] CFG_MARK_STEP  = 3'd4;
	localparam logic [2:0] CFG_SPACE_STEP = 3'd5;
	localparam logic [2:0] CFG_TONE_A     = 3'd6;
	localparam logic [2:0] CFG_TONE_B     = 3'd7;

	// register defaults
	localparam logic [6:0]  RST_MSG_LEN    = 7'd68;
	localparam logic [9:0]  RST_BIT_SAMP   = 10'd85;
	localparam logic [19:0] RST_GAP_SAMP   = 20'd44100;
	localparam logic [19:0] RST_ATTN_SAMP  = 20'd352800;
	localparam logic [31:0] RST_MARK_STEP  = 32'd202895813;
	localparam logic [31:0] RST_SPACE_STEP = 32'd152174294;
	localparam logic [31:0] RST_TONE_A     = 32'd93495887;
	localparam logic [31:0] RST_TONE_B     = 32'd83074981;

	typedef enum logic [3:0] {
		ST_HEADER = 4'b0001,
		ST_ATTN   = 4'b0010,
		ST_EOM    = 4'b0100,
		ST_DONE   = 4'b1000
	} stage_t;

	// table lookups for one sample: one tone, or the average of two
	typedef struct packed {
		logic                 dual;
		logic [SINE_BITS-1:0] idx_a;
		logic [SINE_BITS-1:0] idx_b;
	} tone_req_t;

	typedef logic [14:0] qtr_tab_t [0:QTR_SIZE-1];

	// quarter-wave magnitudes from the integer polynomial approximation
	function automatic qtr_tab_t build_qtr();
		qtr_tab_t    t;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] p;
		logic [63:0] y;
		logic [63:0] s;
		for (int i = 0; i < QTR_SIZE; i++) begin
			x  = 64'(i) << (18 - SINE_BITS);
			x2 = (x * x) >> 16;
			p  = 64'd102944 - ((x2 * (64'd42048 - ((x2 * 64'd4640) >> 16))) >> 16);
			y  = (x * p) >> 16;
			s  = (y * 64'd32767 + 64'd32768) >> 16;
			if (s > 64'd32767) begin
				s = 64'd32767;
			end
			t[i] = s[14:0];
		end
		return t;
	endfunction

	localparam qtr_tab_t QTR_TAB = build_qtr();

	// full-wave sine from the quarter table: mirror odd quadrants, negate the second half-wave
	function automatic logic signed [15:0] sine_lookup(input logic [SINE_BITS-1:0] idx);
		logic [1:0]          quad;
		logic [QTR_BITS:0]   r;
		logic [14:0]         mag;
		logic signed [15:0]  s;
		quad = idx[SINE_BITS-1 -: 2];
		r    = {1'b0, idx[QTR_BITS-1:0]};
		if (quad[0]) begin
			r = (QTR_BITS + 1)'(QTR_SIZE) - r;
		end
		mag = r[QTR_BITS] ? 15'd32767 : QTR_TAB[r[QTR_BITS-1:0]];
		s   = $signed({1'b0, mag});
		return quad[1] ? -s : s;
	endfunction

endpackage

// ----- src/saag_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module saag_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- src/saag_tone.sv -----
// Sine lookup and two-tone averaging for one audio sample.
`timescale 1ns / 1ps
module saag_tone (
	input  saag_pkg::tone_req_t req,
	output logic signed [15:0]  sample
);

	logic signed [15:0] sa;
	logic signed [15:0] sb;
	logic signed [16:0] sum;
	logic signed [16:0] avg;

	always_comb begin
		sa  = saag_pkg::sine_lookup(req.idx_a);
		sb  = saag_pkg::sine_lookup(req.idx_b);
		sum = 17'(sa) + 17'(sb);
		// round toward zero: add one before the shift when negative
		avg = (sum + 17'(sum[16])) >>> 1;
		sample = req.dual ? avg[15:0] : sa;
	end

endmodule

// ----- src/same_afsk_alert_generator.sv -----
// Top level of the SAME alert generator: sequencer, message store and output pipeline.
// An accepted produce item is registered in stage 1, then in stage 2, which drives m_axis.
// Throughput: one item per clock; load, restart and finished-produce items give no sample.
// The sequencer updates in the cycle of acceptance; the sine lookup and tone averaging sit
// between the first and second register stages, so m_axis_tready alone sets the rate.
// Reset (arst_n low) clears the sequence, the phases and the pipeline and loads register
// defaults; the message store keeps no reset value and needs no clearing pass.
`timescale 1ns / 1ps
module same_afsk_alert_generator (
	input  logic        clk,
	input  logic        arst_n,

	// input items
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [6:0] byte_index, [14:7] byte_value, [15] zero
	input  logic [1:0]  s_axis_tuser,   // [1:0] mode

	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] sample (signed)
	output logic [2:0]  m_axis_tuser,   // [1:0] stage_now, [2] burst_end
	output logic        m_axis_tlast,   // last

	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SB = saag_pkg::SINE_BITS;
	localparam int AW = saag_pkg::MSG_AW;

	// ---------------------------------------------------------------- registers
	logic [6:0]  msg_len_q;
	logic [9:0]  bit_samp_q;
	logic [19:0] gap_samp_q;
	logic [19:0] attn_samp_q;
	logic [31:0] mark_step_q;
	logic [31:0] space_step_q;
	logic [31:0] tone_a_step_q;
	logic [31:0] tone_b_step_q;

	// config always accepted; user must write only while the block is idle (not enforced)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_len_q     <= saag_pkg::RST_MSG_LEN;
			bit_samp_q    <= saag_pkg::RST_BIT_SAMP;
			gap_samp_q    <= saag_pkg::RST_GAP_SAMP;
			attn_samp_q   <= saag_pkg::RST_ATTN_SAMP;
			mark_step_q   <= saag_pkg::RST_MARK_STEP;
			space_step_q  <= saag_pkg::RST_SPACE_STEP;
			tone_a_step_q <= saag_pkg::RST_TONE_A;
			tone_b_step_q <= saag_pkg::RST_TONE_B;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				saag_pkg::CFG_MSG_LEN:    msg_len_q     <= cfg_data[6:0];
				saag_pkg::CFG_BIT_SAMP:   bit_samp_q    <= cfg_data[9:0];
				saag_pkg::CFG_GAP_SAMP:   gap_samp_q    <= cfg_data[19:0];
				saag_pkg::CFG_ATTN_SAMP:  attn_samp_q   <= cfg_data[19:0];
				saag_pkg::CFG_MARK_STEP:  mark_step_q   <= cfg_data;
				saag_pkg::CFG_SPACE_STEP: space_step_q  <= cfg_data;
				saag_pkg::CFG_TONE_A:     tone_a_step_q <= cfg_data;
				saag_pkg::CFG_TONE_B:     tone_b_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective register values: zero counts act as one, length saturates
	logic [6:0]  eff_len;
	logic [9:0]  eff_bit;
	logic [19:0] eff_gap;
	logic [19:0] eff_attn;

	always_comb begin
		if (msg_len_q == 7'd0) begin
			eff_len = 7'd1;
		end else if (msg_len_q > 7'(saag_pkg::MAX_MSG_LEN)) begin
			eff_len = 7'(saag_pkg::MAX_MSG_LEN);
		end else begin
			eff_len = msg_len_q;
		end
		eff_bit  = (bit_samp_q  == '0) ? 10'd1 : bit_samp_q;
		eff_gap  = (gap_samp_q  == '0) ? 20'd1 : gap_samp_q;
		eff_attn = (attn_samp_q == '0) ? 20'd1 : attn_samp_q;
	end

	// ---------------------------------------------------------------- handshake
	logic v_s1;
	logic v_s2;
	logic adv_s2;
	logic in_acc;
	logic [1:0] mode;

	// stage 2 takes a new item when empty or being drained; stage 1 follows it
	assign adv_s2        = !v_s2 || m_axis_tready;
	assign s_axis_tready = !v_s1 || adv_s2;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign mode          = s_axis_tuser;

	// ---------------------------------------------------------------- sequence state
	saag_pkg::stage_t stage_q, stage_d;
	logic [1:0]  burst_q, burst_d;
	logic        in_burst_q, in_burst_d;
	logic [6:0]  byte_pos_q, byte_pos_d;
	logic [2:0]  bit_pos_q, bit_pos_d;
	logic        cur_bit_q, cur_bit_d;
	logic [9:0]  bit_timer_q, bit_timer_d;
	logic [19:0] sil_q, sil_d;
	logic [31:0] afsk_ph_q, afsk_ph_d;
	logic [31:0] ta_ph_q, ta_ph_d;
	logic [31:0] tb_ph_q, tb_ph_d;

	// message store: read address follows the next byte position, so the byte
	// for the current position is ready in the cycle it is needed
	logic [7:0]  mem_rd;
	logic [7:0]  mem_byte;
	logic [7:0]  fwd_data_q;
	logic        fwd_hit_q;
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	assign wr_en   = in_acc && (mode == saag_pkg::MODE_LOAD);
	assign wr_addr = AW'(s_axis_tdata[6:0]);
	assign rd_addr = AW'(byte_pos_d - 7'(saag_pkg::PREAMBLE_BYTES));

	saag_ram #(
		.WIDTH(8),
		.DEPTH(saag_pkg::MSG_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(s_axis_tdata[14:7]),
		.rd_addr(rd_addr),
		.rd_data(mem_rd)
	);

	// a load to the address being read in the same cycle wins over the old data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_hit_q <= 1'b0;
		end else begin
			fwd_hit_q <= wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= s_axis_tdata[14:7];
	end

	assign mem_byte = fwd_hit_q ? fwd_data_q : mem_rd;

	// ---------------------------------------------------------------- next state
	logic [7:0]  byte_val;
	logic [6:0]  burst_bytes;
	logic [19:0] sil_dec;
	logic [9:0]  bt;
	logic        cb;
	logic [2:0]  bp;
	logic [6:0]  bytep;
	logic [1:0]  bc;
	logic [1:0]  stage_code;
	logic        res_v;
	logic        be;
	logic        lst;
	saag_pkg::tone_req_t req;

	always_comb begin
		unique case (stage_q)
			saag_pkg::ST_HEADER: stage_code = saag_pkg::STAGE_CODE_HEADER;
			saag_pkg::ST_ATTN:   stage_code = saag_pkg::STAGE_CODE_ATTN;
			saag_pkg::ST_EOM:    stage_code = saag_pkg::STAGE_CODE_EOM;
			default:             stage_code = saag_pkg::STAGE_CODE_HEADER;
		endcase
	end

	always_comb begin
		// byte on air: end-of-message char, preamble, or loaded message
		if (stage_q == saag_pkg::ST_EOM) begin
			byte_val = saag_pkg::EOM_CHAR;
		end else if (byte_pos_q < 7'(saag_pkg::PREAMBLE_BYTES)) begin
			byte_val = saag_pkg::PRE_CHAR;
		end else begin
			byte_val = mem_byte;
		end
		burst_bytes = (stage_q == saag_pkg::ST_EOM) ? 7'(saag_pkg::EOM_BYTES)
			: 7'(saag_pkg::PREAMBLE_BYTES) + eff_len;
		sil_dec = (sil_q != '0) ? sil_q - 20'd1 : '0;

		stage_d     = stage_q;
		burst_d     = burst_q;
		in_burst_d  = in_burst_q;
		byte_pos_d  = byte_pos_q;
		bit_pos_d   = bit_pos_q;
		cur_bit_d   = cur_bit_q;
		bit_timer_d = bit_timer_q;
		sil_d       = sil_q;
		afsk_ph_d   = afsk_ph_q;
		ta_ph_d     = ta_ph_q;
		tb_ph_d     = tb_ph_q;
		bt    = bit_timer_q;
		cb    = cur_bit_q;
		bp    = bit_pos_q;
		bytep = byte_pos_q;
		bc    = burst_q;
		res_v = 1'b0;
		be    = 1'b0;
		lst   = 1'b0;
		req   = '0;

		if (in_acc) begin
			unique case (mode)
				saag_pkg::MODE_RESTART: begin
					stage_d     = saag_pkg::ST_HEADER;
					burst_d     = '0;
					in_burst_d  = 1'b1;
					byte_pos_d  = '0;
					bit_pos_d   = '0;
					cur_bit_d   = 1'b0;
					bit_timer_d = '0;
					sil_d       = '0;
					afsk_ph_d   = '0;
					ta_ph_d     = '0;
					tb_ph_d     = '0;
				end
				saag_pkg::MODE_PRODUCE: begin
					if (stage_q != saag_pkg::ST_DONE) begin
						res_v = 1'b1;
						if (in_burst_q && stage_q == saag_pkg::ST_ATTN) begin
							// attention tone: advance both phases, count down tone length
							ta_ph_d   = ta_ph_q + tone_a_step_q;
							tb_ph_d   = tb_ph_q + tone_b_step_q;
							req.dual  = 1'b1;
							req.idx_a = ta_ph_d[31 -: SB];
							req.idx_b = tb_ph_d[31 -: SB];
							sil_d     = sil_dec;
							if (sil_dec == '0) begin
								be         = 1'b1;
								in_burst_d = 1'b0;
								sil_d      = eff_gap;
							end
						end else if (in_burst_q) begin
							// AFSK bit: fetch a new bit when the bit timer has run out
							if (bit_timer_q == '0) begin
								cb = byte_val[bit_pos_q];
								bt = eff_bit;
							end
							cur_bit_d = cb;
							afsk_ph_d = afsk_ph_q + (cb ? mark_step_q : space_step_q);
							req.idx_a = afsk_ph_d[31 -: SB];
							bt          = bt - 10'd1;
							bit_timer_d = bt;
							if (bt == '0) begin
								bp        = bit_pos_q + 3'd1;
								bytep     = byte_pos_q + 7'(bp == '0);
								bit_pos_d = bp;
								byte_pos_d = bytep;
								if (bytep >= burst_bytes) begin
									be         = 1'b1;
									byte_pos_d = '0;
									bit_pos_d  = '0;
									bc         = burst_q + 2'd1;
									burst_d    = bc;
									if (stage_q == saag_pkg::ST_EOM && bc >= saag_pkg::REPEATS) begin
										lst     = 1'b1;
										stage_d = saag_pkg::ST_DONE;
									end else begin
										in_burst_d = 1'b0;
										sil_d      = eff_gap;
									end
								end
							end
						end else begin
							// silent gap: hold zero output, then move on
							sil_d = sil_dec;
							if (sil_dec == '0) begin
								in_burst_d = 1'b1;
								if (stage_q == saag_pkg::ST_HEADER && burst_q >= saag_pkg::REPEATS) begin
									stage_d = saag_pkg::ST_ATTN;
									burst_d = '0;
									sil_d   = eff_attn;
								end else if (stage_q == saag_pkg::ST_ATTN) begin
									stage_d = saag_pkg::ST_EOM;
									burst_d = '0;
								end
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_q     <= saag_pkg::ST_HEADER;
			burst_q     <= '0;
			in_burst_q  <= 1'b1;
			byte_pos_q  <= '0;
			bit_pos_q   <= '0;
			cur_bit_q   <= 1'b0;
			bit_timer_q <= '0;
			sil_q       <= '0;
			afsk_ph_q   <= '0;
			ta_ph_q     <= '0;
			tb_ph_q     <= '0;
		end else begin
			stage_q     <= stage_d;
			burst_q     <= burst_d;
			in_burst_q  <= in_burst_d;
			byte_pos_q  <= byte_pos_d;
			bit_pos_q   <= bit_pos_d;
			cur_bit_q   <= cur_bit_d;
			bit_timer_q <= bit_timer_d;
			sil_q       <= sil_d;
			afsk_ph_q   <= afsk_ph_d;
			ta_ph_q     <= ta_ph_d;
			tb_ph_q     <= tb_ph_d;
		end
	end

	// ---------------------------------------------------------------- stage 1
	saag_pkg::tone_req_t req_s1;
	logic       silent_s1;
	logic [1:0] stage_s1;
	logic       be_s1;
	logic       last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			v_s1 <= res_v;
		end
	end

	// gap samples carry no tone: mark them so stage 2 drives zero
	always_ff @(posedge clk) begin
		if (s_axis_tready) begin
			req_s1    <= req;
			silent_s1 <= !in_burst_q;
			stage_s1  <= stage_code;
			be_s1     <= be;
			last_s1   <= lst;
		end
	end

	// ---------------------------------------------------------------- stage 2
	logic signed [15:0] tone_smp;
	logic [15:0] sample_s2;
	logic [1:0]  stage_s2;
	logic        be_s2;
	logic        last_s2;

	saag_tone u_tone (
		.req   (req_s1),
		.sample(tone_smp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			sample_s2 <= silent_s1 ? 16'd0 : tone_smp;
			stage_s2  <= stage_s1;
			be_s2     <= be_s1;
			last_s2   <= last_s1;
		end
	end

	assign m_axis_tvalid = v_s2;
	assign m_axis_tdata  = sample_s2;
	assign m_axis_tuser  = {be_s2, stage_s2};
	assign m_axis_tlast  = last_s2;

`ifndef ASSERT_OFF
	// the final sample closes the last end-of-message burst
	a_last_is_eom_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[2]
			&& m_axis_tuser[1:0] == saag_pkg::STAGE_CODE_EOM)
		else $error("last sample is not the end of an end-of-message burst");

	// a produce item after the alert has finished must not enter the pipeline
	a_done_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && mode == saag_pkg::MODE_PRODUCE && stage_q == saag_pkg::ST_DONE |=> !v_s1)
		else $error("sample produced after the alert finished");

	// attention stage leaves the bit counters cleared
	a_attn_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		stage_q == saag_pkg::ST_ATTN |-> byte_pos_q == '0 && bit_pos_q == '0
			&& bit_timer_q == '0)
		else $error("bit counters busy during attention stage");

	// two-tone lookups only belong to the attention stage
	a_dual_in_attn: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && req_s1.dual |-> stage_s1 == saag_pkg::STAGE_CODE_ATTN && !silent_s1)
		else $error("two-tone sample outside the attention tone");
`endif

endmodule

// ----- tb/same_afsk_alert_generator_checker.sv -----
// Checker for the SAME alert generator: predicts each audio sample and compares it on arrival.
`timescale 1ns / 1ps
module same_afsk_alert_generator_checker
	import saag_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic [2:0]  m_axis_tuser,
	input  logic        m_axis_tlast,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          fail_count,
	output int          pending_count
);

	typedef struct packed {
		logic signed [15:0] level;
		logic [1:0]         stage_now;
		logic               burst_end;
		logic               last;
	} alert_sample_t;

	alert_sample_t samples_due [$];
	int            errs;

	// register copies
	logic [6:0]  msg_len;
	logic [9:0]  bit_len;
	logic [19:0] gap_len;
	logic [19:0] attn_len;
	logic [31:0] mark_inc, space_inc, ta_inc, tb_inc;

	// sequencer copy
	logic [7:0]  msg_mem [MSG_DEPTH];
	stage_t      stg;
	logic [1:0]  bursts;
	logic        tone_on;
	logic [6:0]  byte_pos;
	logic [2:0]  bit_pos;
	logic        cur_bit;
	logic [9:0]  bit_left;
	logic [19:0] quiet_left;
	logic [31:0] afsk_ph, ta_ph, tb_ph;

	// quarter-wave polynomial, mirrored and negated by quadrant
	function automatic logic signed [15:0] wave_at(input logic [31:0] phase);
		logic [SINE_BITS-1:0] idx;
		logic [QTR_BITS:0]    pos;
		logic [63:0]          x, x2, p, y, s;
		logic signed [15:0]   mag;
		idx = phase[31 -: SINE_BITS];
		pos = {1'b0, idx[QTR_BITS-1:0]};
		if (idx[SINE_BITS-2]) begin
			pos = (QTR_BITS + 1)'(QTR_SIZE) - pos;
		end
		x  = 64'(pos) << (18 - SINE_BITS);
		x2 = (x * x) >> 16;
		p  = 64'd102944 - ((x2 * (64'd42048 - ((x2 * 64'd4640) >> 16))) >> 16);
		y  = (x * p) >> 16;
		s  = (y * 64'd32767 + 64'd32768) >> 16;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		mag = 16'(s);
		return idx[SINE_BITS-1] ? -mag : mag;
	endfunction

	function automatic logic [1:0] stage_code(input stage_t s);
		case (s)
			ST_ATTN: begin
				return STAGE_CODE_ATTN;
			end
			ST_EOM: begin
				return STAGE_CODE_EOM;
			end
			default: begin
				return STAGE_CODE_HEADER;
			end
		endcase
	endfunction

	function automatic int burst_len();
		int len;
		len = (msg_len == 0) ? 1 : (msg_len > MAX_MSG_LEN) ? MAX_MSG_LEN : int'(msg_len);
		return (stg == ST_EOM) ? EOM_BYTES : PREAMBLE_BYTES + len;
	endfunction

	function automatic logic [7:0] byte_at(input logic [6:0] pos);
		if (stg == ST_EOM) begin
			return EOM_CHAR;
		end
		if (pos < PREAMBLE_BYTES) begin
			return PRE_CHAR;
		end
		return msg_mem[7'(pos - PREAMBLE_BYTES)];
	endfunction

	function automatic logic [19:0] nonzero20(input logic [19:0] v);
		return (v == 0) ? 20'd1 : v;
	endfunction

	task automatic restart_alert();
		stg        = ST_HEADER;
		bursts     = '0;
		tone_on    = 1'b1;
		byte_pos   = '0;
		bit_pos    = '0;
		cur_bit    = 1'b0;
		bit_left   = '0;
		quiet_left = '0;
		afsk_ph    = '0;
		ta_ph      = '0;
		tb_ph      = '0;
	endtask

	task automatic store_setting(input logic [2:0] idx, input logic [31:0] val);
		case (idx)
			CFG_MSG_LEN:    msg_len   = val[6:0];
			CFG_BIT_SAMP:   bit_len   = val[9:0];
			CFG_GAP_SAMP:   gap_len   = val[19:0];
			CFG_ATTN_SAMP:  attn_len  = val[19:0];
			CFG_MARK_STEP:  mark_inc  = val;
			CFG_SPACE_STEP: space_inc = val;
			CFG_TONE_A:     ta_inc    = val;
			CFG_TONE_B:     tb_inc    = val;
			default: ;
		endcase
	endtask

	// advance the sequencer by one input item; queue the sample it yields, if any
	task automatic advance_alert(input logic [1:0] mode, input logic [6:0] idx,
			input logic [7:0] val);
		alert_sample_t due;
		int            level;
		if (mode == MODE_LOAD) begin
			msg_mem[idx] = val;
		end else if (mode == MODE_RESTART) begin
			restart_alert();
		end else if (mode == MODE_PRODUCE && stg != ST_DONE) begin
			due.stage_now = stage_code(stg);
			due.burst_end = 1'b0;
			due.last      = 1'b0;
			level         = 0;
			if (tone_on && stg == ST_ATTN) begin
				ta_ph += ta_inc;
				tb_ph += tb_inc;
				level = (int'(wave_at(ta_ph)) + int'(wave_at(tb_ph))) / 2;
				if (quiet_left != 0) begin
					quiet_left--;
				end
				if (quiet_left == 0) begin
					due.burst_end = 1'b1;
					tone_on       = 1'b0;
					quiet_left    = nonzero20(gap_len);
				end
			end else if (tone_on) begin
				if (bit_left == 0) begin
					cur_bit  = 1'(byte_at(byte_pos) >> bit_pos);
					bit_left = (bit_len == 0) ? 10'd1 : bit_len;
				end
				afsk_ph += cur_bit ? mark_inc : space_inc;
				level = int'(wave_at(afsk_ph));
				bit_left--;
				if (bit_left == 0) begin
					bit_pos = bit_pos + 3'd1;
					if (bit_pos == 0) begin
						byte_pos++;
					end
					if (byte_pos >= burst_len()) begin
						due.burst_end = 1'b1;
						byte_pos      = '0;
						bit_pos       = '0;
						bursts++;
						if (stg == ST_EOM && bursts >= REPEATS) begin
							due.last = 1'b1;
							stg      = ST_DONE;
						end else begin
							tone_on    = 1'b0;
							quiet_left = nonzero20(gap_len);
						end
					end
				end
			end else begin
				if (quiet_left != 0) begin
					quiet_left--;
				end
				if (quiet_left == 0) begin
					tone_on = 1'b1;
					if (stg == ST_HEADER && bursts >= REPEATS) begin
						stg        = ST_ATTN;
						bursts     = '0;
						quiet_left = nonzero20(attn_len);
					end else if (stg == ST_ATTN) begin
						stg    = ST_EOM;
						bursts = '0;
					end
				end
			end
			due.level = 16'(level);
			samples_due.push_back(due);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		alert_sample_t want;
		if (!arst_n) begin
			msg_len   = RST_MSG_LEN;
			bit_len   = RST_BIT_SAMP;
			gap_len   = RST_GAP_SAMP;
			attn_len  = RST_ATTN_SAMP;
			mark_inc  = RST_MARK_STEP;
			space_inc = RST_SPACE_STEP;
			ta_inc    = RST_TONE_A;
			tb_inc    = RST_TONE_B;
			restart_alert();
			samples_due.delete();
			errs = 0;
			fail_count    <= 0;
			pending_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (samples_due.size() == 0) begin
					errs++;
					$error("unexpected item: level %0d stage %0d", $signed(m_axis_tdata),
						m_axis_tuser[1:0]);
				end else begin
					want = samples_due.pop_front();
					if (m_axis_tdata !== want.level) begin
						errs++;
						$error("level: expected %0d, got %0d", want.level, $signed(m_axis_tdata));
					end
					if (m_axis_tuser[1:0] !== want.stage_now) begin
						errs++;
						$error("stage_now: expected %0d, got %0d", want.stage_now, m_axis_tuser[1:0]);
					end
					if (m_axis_tuser[2] !== want.burst_end) begin
						errs++;
						$error("burst_end: expected %0d, got %0d", want.burst_end, m_axis_tuser[2]);
					end
					if (m_axis_tlast !== want.last) begin
						errs++;
						$error("last: expected %0d, got %0d", want.last, m_axis_tlast);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				advance_alert(s_axis_tuser, s_axis_tdata[6:0], s_axis_tdata[14:7]);
			end
			if (cfg_valid && cfg_ready) begin
				store_setting(cfg_index, cfg_data);
			end
			fail_count    <= errs;
			pending_count <= samples_due.size();
		end
	end

endmodule

// ----- tb/same_afsk_alert_generator_tb.sv -----
// Testbench top for the SAME alert generator: stimulus, flow pacing, watchdog and verdict.
`timescale 1ns / 1ps
module same_afsk_alert_generator_tb;
	import saag_pkg::*;

	// the block ignores this kind; no package name exists for it
	localparam logic [1:0] MODE_SPARE = 2'd3;
	// cycles without any handshake before the run is declared hung
	localparam int WATCHDOG_LIMIT = 4000;
	// let the pipeline settle before touching registers
	localparam int SETTLE_CYCLES = 8;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata  = '0;   // [6:0] byte_index, [14:7] byte_value, [15] zero
	logic [1:0]  s_axis_tuser  = '0;   // [1:0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;         // [15:0] sample (signed)
	logic [2:0]  m_axis_tuser;         // [1:0] stage_now, [2] burst_end
	logic        m_axis_tlast;
	logic        cfg_valid     = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index     = '0;
	logic [31:0] cfg_data      = '0;

	int check_errors;
	int pending_count;
	int quiet_cycles = 0;
	int ready_left   = 0;
	bit sender_calm  = 1'b0;

	same_afsk_alert_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	same_afsk_alert_generator_checker alert_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (check_errors),
		.pending_count (pending_count)
	);

	always #1 clk = ~clk;

	// idle length: mostly none or short, now and then long
	function automatic int idle_span();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 55) begin
			return 0;
		end else if (roll < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	// pace the result side: short ready runs, stalls, and now and then a long open stretch
	always @(posedge clk) begin : rx_pace
		int roll;
		if (ready_left != 0) begin
			ready_left <= ready_left - 1;
		end else begin
			roll = $urandom_range(0, 9);
			if (roll == 0) begin
				m_axis_tready <= 1'b1;
				ready_left    <= $urandom_range(50, 200);
			end else if (roll < 6) begin
				m_axis_tready <= 1'b1;
				ready_left    <= $urandom_range(0, 6);
			end else begin
				m_axis_tready <= 1'b0;
				ready_left    <= idle_span();
			end
		end
	end

	// end the run when no channel moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("same_afsk_alert_generator_tb: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// offer one item, optionally after an idle gap, and hold it until accepted;
	// valid stays high afterwards so back-to-back items need no extra edge
	task automatic send_item(input logic [1:0] mode, input logic [6:0] idx,
			input logic [7:0] val);
		int gap;
		if ($urandom_range(0, 63) == 0) begin
			sender_calm = ~sender_calm;
		end
		gap = sender_calm ? 0 : idle_span();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {1'b0, val, idx};
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
	endtask

	// drop valid, wait out every pending sample, then let the pipeline settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_count != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// hold one register write until accepted; the caller lowers valid after the last one
	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
	endtask

	task automatic apply_settings(input logic [6:0] msg_len, input logic [9:0] bit_len,
			input logic [19:0] gap_len, input logic [19:0] attn_len,
			input logic [31:0] mark_inc, input logic [31:0] space_inc,
			input logic [31:0] ta_inc, input logic [31:0] tb_inc);
		write_reg(CFG_MSG_LEN, 32'(msg_len));
		write_reg(CFG_BIT_SAMP, 32'(bit_len));
		write_reg(CFG_GAP_SAMP, 32'(gap_len));
		write_reg(CFG_ATTN_SAMP, 32'(attn_len));
		write_reg(CFG_MARK_STEP, mark_inc);
		write_reg(CFG_SPACE_STEP, space_inc);
		write_reg(CFG_TONE_A, ta_inc);
		write_reg(CFG_TONE_B, tb_inc);
		cfg_valid <= 1'b0;
	endtask

	// start a fresh alert and feed it mostly sample requests, with loads and unused
	// kinds sprinkled in; restarts only where the phase need not reach the end
	task automatic run_phase(input int produces, input bit allow_restart);
		int made;
		int roll;
		made = 0;
		send_item(MODE_RESTART, 7'($urandom), 8'($urandom));
		while (made < produces) begin
			roll = $urandom_range(0, 999);
			if (roll < 930) begin
				send_item(MODE_PRODUCE, 7'($urandom), 8'($urandom));
				made++;
			end else if (roll < 970) begin
				send_item(MODE_LOAD, 7'($urandom), 8'($urandom));
			end else if (roll < 985 || !allow_restart) begin
				send_item(MODE_SPARE, 7'($urandom), 8'($urandom));
			end else begin
				send_item(MODE_RESTART, 7'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole message store so no unwritten entry is ever read
		for (int i = 0; i < MSG_DEPTH; i++) begin
			send_item(MODE_LOAD, 7'(i), 8'($urandom));
		end

		// directed: index and value extremes, the unused kind, restart mid-burst,
		// samples under the reset defaults
		send_item(MODE_LOAD, 7'd0, 8'hFF);
		send_item(MODE_LOAD, 7'd127, 8'h00);
		send_item(MODE_SPARE, 7'h7F, 8'hFF);
		repeat (6) send_item(MODE_PRODUCE, 7'h00, 8'h00);
		send_item(MODE_RESTART, 7'h7F, 8'hFF);
		repeat (8) send_item(MODE_PRODUCE, 7'h7F, 8'hFF);
		send_item(MODE_SPARE, 7'h00, 8'h00);
		repeat (3) send_item(MODE_PRODUCE, 7'h2A, 8'h55);
		drain();

		// shortest everything (zeros act as one), extreme steps: run the whole alert,
		// then keep asking after the final sample
		apply_settings(7'd0, 10'd0, 20'd0, 20'd0, 32'hFFFF_FFFF, 32'h0000_0000,
			32'h0000_0000, 32'hFFFF_FFFF);
		run_phase(850, 1'b0);
		drain();

		// oversized length saturates to the longest message; restarts allowed
		apply_settings(7'd127, 10'd1, 20'd3, 20'd5, $urandom, $urandom, $urandom, $urandom);
		run_phase(200, 1'b1);
		drain();

		// largest timings: only the start of the first bit is reachable
		apply_settings(7'd100, 10'd1023, 20'hFFFFF, 20'hFFFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h4000_0000, 32'hC000_0000);
		run_phase(50, 1'b1);
		drain();

		// small random settings so the alert completes with a longer attention tone
		apply_settings(7'($urandom_range(1, 2)), 10'd1, 20'($urandom_range(1, 4)),
			20'($urandom_range(1, 16)), $urandom, $urandom, $urandom, $urandom);
		run_phase(900, 1'b0);
		drain();

		if (check_errors == 0) begin
			$display("same_afsk_alert_generator_tb: done, clean");
		end else begin
			$display("same_afsk_alert_generator_tb: done, errors");
		end
		$finish;
	end

endmodule
